/* hw/rtl/tvfe_pkg.sv */
`timescale 1ns / 1ps

package tvfe_pkg;

   localparam int BYTE_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int CMD_W       = 4;
   localparam int REQ_TDATA_W = 80;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_UINT  = 2'd0;
   localparam logic [1:0] KIND_INT   = 2'd1;
   localparam logic [1:0] KIND_FIXED = 2'd2;

   localparam logic [BYTE_W-1:0] TAG_OFFSET_RESET = 8'd4;

   typedef enum logic [1:0] {
      MODE_VARINT   = 2'd0,
      MODE_FIXED    = 2'd1,
      MODE_TAG_ONLY = 2'd2
   } mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  tag;
      mode_type           mode;
      logic [2:0]         fixed_last;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

/* hw/rtl/tvfe_front.sv */
`timescale 1ns / 1ps

module tvfe_front
   import tvfe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [BYTE_W-1:0]  csr_wr_data,
   input  logic [CMD_W-1:0]   cmd,
   input  logic [BYTE_W-1:0]  field_index,
   input  logic [VALUE_W-1:0] value,
   output entry_type          entry
);

   logic [BYTE_W-1:0]  tag_offset_ff;
   logic [BYTE_W-1:0]  tag_offset_in;
   logic [1:0]         size;
   logic [1:0]         kind;
   logic [VALUE_W-1:0] masked;
   logic [VALUE_W-1:0] zigzag;
   logic [2:0]         fixed_last;

   assign tag_offset_in = csr_wr_en ? csr_wr_data : tag_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_offset_ff <= TAG_OFFSET_RESET;
      end else begin
         tag_offset_ff <= tag_offset_in;
      end
   end

   assign size = cmd[1:0];
   assign kind = cmd[3:2];

   always_comb begin
      case (size)
         2'd0: begin
            masked     = {56'd0, value[7:0]};
            zigzag     = {56'd0, {value[6:0], 1'b0} ^ {8{value[7]}}};
            fixed_last = 3'd0;
         end
         2'd1: begin
            masked     = {48'd0, value[15:0]};
            zigzag     = {48'd0, {value[14:0], 1'b0} ^ {16{value[15]}}};
            fixed_last = 3'd1;
         end
         2'd2: begin
            masked     = {32'd0, value[31:0]};
            zigzag     = {32'd0, {value[30:0], 1'b0} ^ {32{value[31]}}};
            fixed_last = 3'd3;
         end
         default: begin
            masked     = value;
            zigzag     = {value[62:0], 1'b0} ^ {64{value[63]}};
            fixed_last = 3'd7;
         end
      endcase
   end

   always_comb begin
      entry.tag        = field_index + tag_offset_ff;
      entry.fixed_last = fixed_last;
      case (kind)
         KIND_UINT: begin
            entry.mode  = MODE_VARINT;
            entry.value = masked;
         end
         KIND_INT: begin
            entry.mode  = MODE_FIXED;
            entry.value = zigzag;
         end
         KIND_FIXED: begin
            entry.mode  = MODE_FIXED;
            entry.value = masked;
         end
         default: begin
            entry.mode  = MODE_TAG_ONLY;
            entry.value = masked;
         end
      endcase
   end

endmodule

/* hw/rtl/tvfe_queue.sv */
`timescale 1ns / 1ps

module tvfe_queue
   import tvfe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head_entry
);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;

   assign full       = (count_ff == QUEUE_DEPTH[QUEUE_PTR_W:0]);
   assign not_empty  = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_DEPTH[QUEUE_PTR_W:0])
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

/* hw/rtl/tvfe_back.sv */
`timescale 1ns / 1ps

module tvfe_back
   import tvfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  entry_type         q_entry,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_VARINT = 3'b010,
      ST_FIXED  = 3'b100
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] val_in;
   logic [2:0]         cnt_ff;
   logic [2:0]         cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_data_ff;
   logic [BYTE_W-1:0]  rsp_data_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      if (out_free) begin
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = q_entry.tag;
                  rsp_last_in  = (q_entry.mode == MODE_TAG_ONLY);
                  val_in       = q_entry.value;
                  cnt_in       = q_entry.fixed_last;
                  case (q_entry.mode)
                     MODE_VARINT: state_in = ST_VARINT;
                     MODE_FIXED:  state_in = ST_FIXED;
                     default:     state_in = ST_IDLE;
                  endcase
               end
            end
            ST_VARINT: begin
               rsp_valid_in = 1'b1;
               if (val_ff[VALUE_W-1:7] != '0) begin
                  rsp_data_in = {1'b1, val_ff[6:0]};
                  rsp_last_in = 1'b0;
                  val_in      = val_ff >> 7;
               end else begin
                  rsp_data_in = val_ff[BYTE_W-1:0];
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
            ST_FIXED: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = val_ff[BYTE_W-1:0];
               rsp_last_in  = (cnt_ff == '0);
               val_in       = val_ff >> BYTE_W;
               cnt_in       = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while serialising");

   a_tag_only_last: assert property (@(posedge clock) disable iff (reset)
      (pop && q_entry.mode == MODE_TAG_ONLY) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("tag-only request not flagged last");

   a_varint_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VARINT && out_free && val_ff[VALUE_W-1:7] != '0)
      |=> (state_ff == ST_VARINT && !rsp_last_ff))
      else $error("varint ended early");

endmodule

/* hw/rtl/tagged_varint_field_encoder.sv */
`timescale 1ns / 1ps
// Tagged varint field encoder.
// Request channel (req_*): one attribute per request, carrying the type code,
// field index and 64 raw value bits. Response channel (rsp_*): one serialised
// byte per beat, the tag byte (field index + tag offset, mod 256) first, then
// the value bytes; rsp_tlast marks the final byte of each attribute.
// Unsigned types give a base-128 varint, signed types a zigzag-encoded
// fixed-width field, fixed types a plain little-endian field, unused type
// codes the tag byte alone.
// csr_wr_en / csr_wr_data write the tag offset; write only while idle.
// A taken request enters the queue; the idle serialiser pops it and registers
// its tag byte. While the receiver accepts, it emits one byte per cycle, tag
// then value bytes, and pops the next request after the last. A two-entry queue
// between classifier and serialiser lets requests be taken while bytes drain.
// Reset clears the queue and the output register and sets the tag offset to 4.
// When the receiver stalls the current byte holds, the serialiser stops, and
// req_tready drops once the queue is full.
module tagged_varint_field_encoder
   import tvfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [BYTE_W-1:0]      csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // cmd[3:0], field_index[11:4], value[75:12]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,  // out_byte[7:0]
   output logic                   rsp_tlast
);

   entry_type front_entry;
   entry_type head_entry;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;
   logic      q_push;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   tvfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (req_tdata[3:0]),
      .field_index (req_tdata[11:4]),
      .value       (req_tdata[75:12]),
      .entry       (front_entry)
   );

   tvfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   tvfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_entry    (head_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
